/* src/assert_macros.svh */
// assertion macros shared by the dimmer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is held
`define DBL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dimmer assertion failed");

// same with a caller supplied message
`define DBL_ASSERT_MSG(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

/* src/dbled_pkg.sv */
// shared types and constants of the pwm led dimmer
package dbled_pkg;

  localparam int unsigned TIME_WIDTH_DEF  = 24;
  localparam int unsigned LEVEL_WIDTH_DEF = 8;

  localparam int unsigned CFG_TIME_W  = 24;
  localparam int unsigned CFG_LEVEL_W = 8;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 4;

  localparam logic [CFG_TIME_W-1:0]  DEBOUNCE_RST = 24'd200;
  localparam logic [CFG_TIME_W-1:0]  PERIOD_RST   = 24'd100000;
  localparam logic [CFG_LEVEL_W-1:0] MAX_RST      = 8'd5;
  localparam logic [PCT_W-1:0]       PCT_SCALE    = 7'd100;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_PERIOD   = 2'd1,
    REG_MAX      = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_ON_START  = 6'b000010,
    ST_ON_WAIT   = 6'b000100,
    ST_PCT_START = 6'b001000,
    ST_PCT_WAIT  = 6'b010000,
    ST_FINISH    = 6'b100000
  } ctrl_state_e;

  typedef enum logic {
    DIV_ON  = 1'b0,
    DIV_PCT = 1'b1
  } div_sel_e;

  typedef struct packed {
    logic     step;
    logic     div_start;
    div_sel_e div_sel;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } dp_sts_t;

endpackage

/* src/dbled_div.sv */
// restoring divider, one quotient bit per cycle
module dbled_div import dbled_pkg::*; #(
  parameter int unsigned NUM_W = 32,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W+1:0] trial;

  always_comb begin
    trial  = {1'b0, rem_q, num_q[NUM_W-1]} - {2'b00, den_q};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = CNT_W'(NUM_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (!trial[DEN_W+1]) begin
        rem_d = trial[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DEN_W-2:0], num_q[NUM_W-1]};
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

/* src/dbled_dp.sv */
// datapath: elapsed counters, level, pwm pin and result register
`include "assert_macros.svh"

module dbled_dp import dbled_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_cmd_t                cmd_i,
  output dp_sts_t                sts_o,
  input  logic                   up_press_i,
  input  logic                   down_press_i,
  input  logic [CFG_TIME_W-1:0]  debounce_i,
  input  logic [CFG_TIME_W-1:0]  period_i,
  input  logic [CFG_LEVEL_W-1:0] max_level_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   led_out_o,
  output logic [CFG_LEVEL_W-1:0] brightness_level_o,
  output logic [PCT_W-1:0]       brightness_percent_o
);

  localparam int unsigned CW    = (TIME_WIDTH > CFG_TIME_W) ? TIME_WIDTH : CFG_TIME_W;
  localparam int unsigned MW    = (LEVEL_WIDTH > CFG_LEVEL_W) ? LEVEL_WIDTH : CFG_LEVEL_W;
  localparam int unsigned NUM_W = CFG_TIME_W + LEVEL_WIDTH;

  logic [TIME_WIDTH-1:0]  since_down_q, since_up_q, since_toggle_q;
  logic [TIME_WIDTH-1:0]  sd_inc, su_inc, st_inc;
  logic [LEVEL_WIDTH-1:0] level_q, lvl_dn, lvl_up, mx;
  logic                   pin_q;
  logic                   down_ok, up_ok;
  logic [MW-1:0]          mx_wide;
  logic [MW-1:0]          lvl_wide;
  logic [CFG_TIME_W-1:0]  on_t_q, need;
  logic [NUM_W-1:0]       pct_q;
  logic [NUM_W-1:0]       div_num, div_quot;
  logic                   div_done;
  div_sel_e               sel_q;
  logic                   out_busy, load, toggle, pin_next;
  logic                   out_valid_q, led_q;
  logic [CFG_LEVEL_W-1:0] lvl_out_q;
  logic [PCT_W-1:0]       pct_out_q;

  function automatic logic [TIME_WIDTH-1:0] sat_inc(input logic [TIME_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

  // effective maximum level
  always_comb begin
    mx_wide = (max_level_i == '0) ? MW'(1) : MW'(max_level_i);
    if (mx_wide > MW'({LEVEL_WIDTH{1'b1}})) begin
      mx_wide = MW'({LEVEL_WIDTH{1'b1}});
    end
    mx = mx_wide[LEVEL_WIDTH-1:0];
  end

  always_comb begin
    sd_inc  = sat_inc(since_down_q);
    su_inc  = sat_inc(since_up_q);
    st_inc  = sat_inc(since_toggle_q);
    down_ok = down_press_i && (CW'(sd_inc) >= CW'(debounce_i));
    up_ok   = up_press_i && (CW'(su_inc) >= CW'(debounce_i));
    lvl_dn  = (down_ok && level_q != '0) ? level_q - 1'b1 : level_q;
    lvl_up  = (up_ok && lvl_dn < mx) ? lvl_dn + 1'b1 : lvl_dn;
  end

  assign div_num = (cmd_i.div_sel == DIV_PCT)
                 ? NUM_W'(PCT_SCALE) * NUM_W'(level_q)
                 : NUM_W'(period_i) * NUM_W'(level_q);

  dbled_div #(
    .NUM_W (NUM_W),
    .DEN_W (LEVEL_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (mx),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_busy = out_valid_q && out_stall_i;
  assign load     = cmd_i.finish && !out_busy;

  always_comb begin
    need     = pin_q ? on_t_q : period_i - on_t_q;
    toggle   = 1'b0;
    pin_next = pin_q;
    if (level_q == '0) begin
      pin_next = 1'b0;
    end else if (level_q >= mx) begin
      pin_next = 1'b1;
    end else if (CW'(since_toggle_q) >= CW'(need)) begin
      toggle   = 1'b1;
      pin_next = !pin_q;
    end
  end

  assign lvl_wide = MW'(level_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      since_down_q   <= '0;
      since_up_q     <= '0;
      since_toggle_q <= '0;
      level_q        <= '0;
      pin_q          <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        since_down_q   <= down_ok ? '0 : sd_inc;
        since_up_q     <= up_ok ? '0 : su_inc;
        since_toggle_q <= st_inc;
        level_q        <= lvl_up;
      end else if (load && toggle) begin
        since_toggle_q <= '0;
      end
      if (load) begin
        pin_q       <= pin_next;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sel_q <= cmd_i.div_sel;
    end
    if (div_done) begin
      if (sel_q == DIV_PCT) begin
        pct_q <= div_quot;
      end else begin
        on_t_q <= div_quot[CFG_TIME_W-1:0];
      end
    end
    if (load) begin
      led_q     <= pin_next;
      lvl_out_q <= lvl_wide[CFG_LEVEL_W-1:0];
      pct_out_q <= (pct_q > NUM_W'(PCT_SCALE)) ? PCT_SCALE : pct_q[PCT_W-1:0];
    end
  end

  assign sts_o.div_done       = div_done;
  assign sts_o.out_busy       = out_busy;
  assign out_valid_o          = out_valid_q;
  assign led_out_o            = led_q;
  assign brightness_level_o   = lvl_out_q;
  assign brightness_percent_o = pct_out_q;

  `DBL_ASSERT(a_level_hold, !cmd_i.step |=> $stable(level_q))
  `DBL_ASSERT(a_out_load, (cmd_i.finish && !out_busy) |=> out_valid_q)
  `DBL_ASSERT_MSG(a_toggle_clear, (load && toggle) |=> (since_toggle_q == '0),
    "pwm toggle did not restart its counter")

endmodule

/* src/dbled_ctrl.sv */
// controller state machine sequencing one tick
module dbled_ctrl import dbled_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{step: 1'b0, div_start: 1'b0, div_sel: DIV_ON, finish: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          state_d    = ST_ON_START;
        end
      end
      ST_ON_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_ON;
        state_d         = ST_ON_WAIT;
      end
      ST_ON_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_PCT_START;
        end
      end
      ST_PCT_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PCT;
        state_d         = ST_PCT_WAIT;
      end
      ST_PCT_WAIT: begin
        if (sts_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (!sts_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

/* src/debounced_button_pwm_led_dimmer_unit.sv */
// top level of the debounced button pwm led dimmer
//
// each request on the input channel is one time tick carrying the up and
// down button edge flags; every request yields exactly one result with the
// led pin level, the brightness level and the brightness percent.
// input: in_valid_i / in_stall_o, accepted when valid is high and stall low.
// output: out_valid_o / out_stall_i, taken when valid is high and stall low.
// one tick is in work at a time: in_stall_o is high from acceptance until
// the result is loaded into the output register.
// the shared one-bit-per-cycle divider computes the pwm high time and then
// the percent for each tick; the next tick can be accepted in the cycle in
// which out_valid_o goes high.
// a waiting result does not block acceptance; a tick finishing while the
// receiver stalls holds in its last step until the output register frees.
// configuration: apb writes to debounce (0x0), period (0x4), max level
// (0x8), only while idle; reads return the register value.
// reset clears level, pin and all elapsed counters and loads the register
// defaults: debounce 200, period 100000, max level 5.
module debounced_button_pwm_led_dimmer_unit import dbled_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
  parameter int unsigned LEVEL_WIDTH = LEVEL_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   up_press_i,
  input  logic                   down_press_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   led_out_o,
  output logic [CFG_LEVEL_W-1:0] brightness_level_o,
  output logic [PCT_W-1:0]       brightness_percent_o
);

  logic [CFG_TIME_W-1:0]  debounce_q, period_q;
  logic [CFG_LEVEL_W-1:0] max_level_q;
  logic                   wr_en;
  reg_idx_e               reg_idx;
  dp_cmd_t                cmd;
  dp_sts_t                sts;
  logic                   accept;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DEBOUNCE_RST;
      period_q    <= PERIOD_RST;
      max_level_q <= MAX_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DEBOUNCE: debounce_q  <= pwdata[CFG_TIME_W-1:0];
        REG_PERIOD:   period_q    <= pwdata[CFG_TIME_W-1:0];
        REG_MAX:      max_level_q <= pwdata[CFG_LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_q);
      REG_PERIOD:   prdata = APB_DATA_W'(period_q);
      REG_MAX:      prdata = APB_DATA_W'(max_level_q);
      default:      prdata = '0;
    endcase
  end

  dbled_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dbled_dp #(
    .TIME_WIDTH  (TIME_WIDTH),
    .LEVEL_WIDTH (LEVEL_WIDTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .up_press_i           (up_press_i),
    .down_press_i         (down_press_i),
    .debounce_i           (debounce_q),
    .period_i             (period_q),
    .max_level_i          (max_level_q),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .led_out_o            (led_out_o),
    .brightness_level_o   (brightness_level_o),
    .brightness_percent_o (brightness_percent_o)
  );

  assign accept = in_valid_i && !in_stall_o;

  `DBL_ASSERT(a_accept_steps, accept |-> cmd.step)
  `DBL_ASSERT(a_no_step_busy, in_stall_o |-> !cmd.step)
  `DBL_ASSERT_MSG(a_cfg_idle, (wr_en && reg_idx != REG_NONE) |-> !in_stall_o,
    "configuration written while a tick is in work")

endmodule

/* tb/testbench.sv */
// testbench for the debounced button pwm led dimmer: directed table, random ticks, predictor check
module testbench import dbled_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_TICKS = 1650;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT = 150;
  localparam int unsigned DIR_ROWS   = 26;

  typedef enum logic {
    ROW_TICK = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    logic                   led;
    logic [CFG_LEVEL_W-1:0] level;
    logic [PCT_W-1:0]       pct;
  } lamp_t;

  typedef struct packed {
    row_kind_e kind;
    reg_idx_e  ridx;
    logic [31:0] val;
    logic      up;
    logic      dn;
    logic      chk;
    lamp_t     want;
  } dir_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   up_press_i = 1'b0;
  logic                   down_press_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic                   led_out_o;
  logic [CFG_LEVEL_W-1:0] brightness_level_o;
  logic [PCT_W-1:0]       brightness_percent_o;

  // predictor state and its copy of the registers
  logic [CFG_LEVEL_W-1:0]    lvl_q;
  logic                      pin_q;
  logic [TIME_WIDTH_DEF-1:0] since_tgl;
  logic [TIME_WIDTH_DEF-1:0] since_dn;
  logic [TIME_WIDTH_DEF-1:0] since_up;
  logic [CFG_TIME_W-1:0]     debounce_cfg;
  logic [CFG_TIME_W-1:0]     period_cfg;
  logic [CFG_LEVEL_W-1:0]    max_cfg;

  lamp_t       lamp_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  lamp_t       seen_want;

  dir_row_t dir_plan [0:DIR_ROWS-1] = '{
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b0, 1'b1, '{1'b0, 8'd0, 7'd0}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b0, 8'd0, 7'd0}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b1, 1'b1, '{1'b0, 8'd0, 7'd0}},
    '{ROW_CFG,  REG_NONE,     32'd7,        1'b0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DEBOUNCE, 32'd0,        1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b1, 1'b1, '{1'b0, 8'd1, 7'd20}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b0, 8'd2, 7'd40}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b0, 8'd3, 7'd60}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b0, 8'd4, 7'd80}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b1, 8'd5, 7'd100}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b1, 8'd5, 7'd100}},
    '{ROW_CFG,  REG_MAX,      32'd2,        1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b1, 1'b1, '{1'b1, 8'd4, 7'd100}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b1, 8'd4, 7'd100}},
    '{ROW_CFG,  REG_MAX,      32'd0,        1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b0, 1'b1, '{1'b1, 8'd4, 7'd100}},
    '{ROW_CFG,  REG_MAX,      32'd255,      1'b0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD,   32'd0,        1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b0, 1'b1, '{1'b0, 8'd4, 7'd1}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b0, 1'b1, '{1'b1, 8'd4, 7'd1}},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b0, 1'b1, 1'b1, '{1'b0, 8'd3, 7'd1}},
    '{ROW_CFG,  REG_PERIOD,   32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  REG_DEBOUNCE, 32'h00FFFFFF, 1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b0, 1'b1, '{1'b0, 8'd3, 7'd1}},
    '{ROW_CFG,  REG_PERIOD,   32'd10,       1'b0, 1'b0, 1'b0, '0},
    '{ROW_TICK, REG_NONE,     32'd0,        1'b1, 1'b1, 1'b0, '0}
  };

  debounced_button_pwm_led_dimmer_unit u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .up_press_i           (up_press_i),
    .down_press_i         (down_press_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .led_out_o            (led_out_o),
    .brightness_level_o   (brightness_level_o),
    .brightness_percent_o (brightness_percent_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic lamp_t dimmer_tick(input logic up, input logic dn);
    logic [CFG_LEVEL_W-1:0] mx;
    logic [63:0]            on_t;
    logic [63:0]            need;
    logic [63:0]            pct;
    lamp_t                  res;
    mx = (max_cfg == '0) ? CFG_LEVEL_W'(1) : max_cfg;
    if (since_dn != '1) since_dn = since_dn + 1'b1;
    if (since_up != '1) since_up = since_up + 1'b1;
    if (since_tgl != '1) since_tgl = since_tgl + 1'b1;
    if (dn && since_dn >= debounce_cfg) begin
      since_dn = '0;
      if (lvl_q != '0) lvl_q = lvl_q - 1'b1;
    end
    if (up && since_up >= debounce_cfg) begin
      since_up = '0;
      if (lvl_q < mx) lvl_q = lvl_q + 1'b1;
    end
    if (lvl_q == '0) begin
      pin_q = 1'b0;
    end else if (lvl_q >= mx) begin
      pin_q = 1'b1;
    end else begin
      on_t = (64'(period_cfg) * 64'(lvl_q)) / 64'(mx);
      need = pin_q ? on_t : 64'(period_cfg) - on_t;
      if (64'(since_tgl) >= need) begin
        pin_q = ~pin_q;
        since_tgl = '0;
      end
    end
    pct = (64'(100) * 64'(lvl_q)) / 64'(mx);
    if (pct > 64'(100)) pct = 64'(100);
    res.led = pin_q;
    res.level = lvl_q;
    res.pct = pct[PCT_W-1:0];
    return res;
  endfunction

  // drive one request and hold it until taken
  task automatic send_tick(input logic up, input logic dn, input logic typed, input lamp_t want);
    lamp_t guess;
    up_press_i <= up;
    down_press_i <= dn;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    guess = dimmer_tick(up, dn);
    lamp_q.push_back(typed ? want : guess);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd_want;
    in_valid_i <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_DEBOUNCE: debounce_cfg = val[CFG_TIME_W-1:0];
      REG_PERIOD:   period_cfg = val[CFG_TIME_W-1:0];
      REG_MAX:      max_cfg = val[CFG_LEVEL_W-1:0];
      default: ;
    endcase
    if (idx == REG_NONE) begin
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
    end else begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      @(posedge clk_i);
      case (idx)
        REG_DEBOUNCE: rd_want = 32'(debounce_cfg);
        REG_PERIOD:   rd_want = 32'(period_cfg);
        default:      rd_want = 32'(max_cfg);
      endcase
      if (prdata !== rd_want) begin
        $error("prdata expected %0h got %0h", rd_want, prdata);
        err_cnt++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // result check and receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lamp_q.size() == 0) begin
        $error("result with nothing expected: led_out %0d brightness_level %0d",
               led_out_o, brightness_level_o);
        err_cnt++;
      end else begin
        seen_want = lamp_q.pop_front();
        if (led_out_o !== seen_want.led) begin
          $error("led_out expected %0d got %0d", seen_want.led, led_out_o);
          err_cnt++;
        end
        if (brightness_level_o !== seen_want.level) begin
          $error("brightness_level expected %0d got %0d", seen_want.level, brightness_level_o);
          err_cnt++;
        end
        if (brightness_percent_o !== seen_want.pct) begin
          $error("brightness_percent expected %0d got %0d", seen_want.pct,
                 brightness_percent_o);
          err_cnt++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 400);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0, 1:    out_stall_i <= 1'b0;
      2:       out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cnt = 0;
    else idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned gap;
    int unsigned up_pct;
    int unsigned dn_pct;
    int unsigned pick;
    logic [31:0] v;
    lvl_q = '0;
    pin_q = 1'b0;
    since_tgl = '0;
    since_dn = '0;
    since_up = '0;
    debounce_cfg = DEBOUNCE_RST;
    period_cfg = PERIOD_RST;
    max_cfg = MAX_RST;
    sent = 0;
    burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_plan[i]) begin
      if (dir_plan[i].kind == ROW_CFG) cfg_write(dir_plan[i].ridx, dir_plan[i].val);
      else send_tick(dir_plan[i].up, dir_plan[i].dn, dir_plan[i].chk, dir_plan[i].want);
    end
    cfg_write(REG_MAX, 32'd5);
    cfg_write(REG_DEBOUNCE, 32'd3);
    for (int k = 0; k < 6; k++) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);

    while (sent < RAND_TICKS) begin
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'h00FFFFFF : 32'($urandom_range(0, 12));
        cfg_write(REG_DEBOUNCE, v | ($urandom() & 32'hFF000000));
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'h00FFFFFF
          : 32'($urandom_range(2, 400));
        cfg_write(REG_PERIOD, v | ($urandom() & 32'hFF000000));
      end
      if ($urandom_range(0, 2) != 0) begin
        pick = $urandom_range(0, 9);
        v = (pick == 0) ? 32'd0 : (pick == 1) ? 32'd1 : (pick == 2) ? 32'd255
          : 32'($urandom_range(2, 8));
        cfg_write(REG_MAX, v | ($urandom() & 32'hFFFFFF00));
      end
      if ($urandom_range(0, 15) == 0) cfg_write(REG_NONE, $urandom());
      phase_len = $urandom_range(40, 160);
      up_pct = $urandom_range(0, 100);
      dn_pct = $urandom_range(0, 100);
      for (int k = 0; k < phase_len && sent < RAND_TICKS; k++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap != 0) begin
            in_valid_i <= 1'b0;
            repeat (gap) @(posedge clk_i);
          end
          burst_left = $urandom_range(1, 40);
        end
        send_tick($urandom_range(0, 99) < up_pct, $urandom_range(0, 99) < dn_pct, 1'b0, '0);
        burst_left--;
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (lamp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
